[src/ms_pkg.sv]
// Shared constants and types for the merge sorter.
package ms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [IDX_W-1:0]        index_t;

endpackage

[src/merge_sorter.sv]
// Merge sorter top level: load, bottom-up merge passes and emit sequencer.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   item    | in        | item_valid / item_ready   | value, last
//   res     | out       | res_valid / res_ready     | sorted_value, final_res, overflow
//
// Loading accepts one word per cycle. On a word with last set, the merge
// sequencer runs ceil(log2(n)) passes; each element is a registered store
// read (S_RD), then a compare and write (S_WR); each run and each pass add
// a setup state (S_RUN, S_PASS). Emitting reads each word (S_EM_RD), then
// shows it until taken. The one comparator and 2-read/1-write stores set this pace.
// Reset (rst, synchronous) clears the count, the drop flag and the sequencer;
// the stores need no clearing. item_ready is low from the last word until the
// final result is taken; a stalled result holds its value.
module merge_sorter (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  ms_pkg::value_t value,
  input  logic          last,
  output logic          res_valid,
  input  logic          res_ready,
  output ms_pkg::value_t sorted_value,
  output logic          final_res,
  output logic          overflow
);
  import ms_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PASS    = 3'd1;
  localparam logic [2:0] S_RUN     = 3'd2;
  localparam logic [2:0] S_RD      = 3'd3;
  localparam logic [2:0] S_WR      = 3'd4;
  localparam logic [2:0] S_EM_RD   = 3'd5;
  localparam logic [2:0] S_EM_SHOW = 3'd6;

  logic [2:0] state;
  count_t     count;      // number of values held
  logic       dropped;    // a value was dropped this set
  logic       bank;       // store that holds the current source (0 = element store)
  count_t     width;      // current run width
  count_t     lo, mid, hi, a, b, k;
  index_t     e;          // emit index

  // Element store and scratch store: one write port, two registered reads.
  value_t mem_elem [MAX_ITEMS];
  value_t mem_scr  [MAX_ITEMS];
  value_t elem_rd0, elem_rd1, scr_rd0, scr_rd1;

  logic   elem_we, scr_we, rd_en;
  index_t wr_addr, rd_addr0, rd_addr1;
  value_t wr_data;

  // Merge arithmetic
  logic [CNT_W:0] sum_mid, sum_hi, width_dbl;
  count_t         mid_c, hi_c, count_inc, k_inc;
  value_t         src0, src1;
  logic           take_a, item_acc, store_room;

  assign item_ready = (state == S_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign store_room = (count < CNT_W'(MAX_ITEMS));
  assign count_inc  = count + CNT_W'(1);

  assign sum_mid   = {1'b0, lo} + {1'b0, width};
  assign width_dbl = {width, 1'b0};
  assign sum_hi    = {1'b0, lo} + width_dbl;
  assign mid_c     = (sum_mid > {1'b0, count}) ? count : sum_mid[CNT_W-1:0];
  assign hi_c      = (sum_hi  > {1'b0, count}) ? count : sum_hi[CNT_W-1:0];
  assign k_inc     = k + CNT_W'(1);

  assign src0 = bank ? scr_rd0 : elem_rd0;
  assign src1 = bank ? scr_rd1 : elem_rd1;

  // Take the left run on ties; fall back to whichever run still has data.
  assign take_a = (a < mid) && ((b >= hi) || (src0 <= src1));

  // Store port control
  always_comb begin
    elem_we  = 1'b0;
    scr_we   = 1'b0;
    wr_addr  = count[IDX_W-1:0];
    wr_data  = value;
    rd_en    = 1'b0;
    rd_addr0 = a[IDX_W-1:0];
    rd_addr1 = b[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        elem_we = item_acc && store_room;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_WR: begin
        // write into the store opposite the source
        elem_we = bank;
        scr_we  = !bank;
        wr_addr = k[IDX_W-1:0];
        wr_data = take_a ? src0 : src1;
      end
      S_EM_RD: begin
        rd_en    = 1'b1;
        rd_addr0 = e;
        rd_addr1 = e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      mem_elem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      elem_rd0 <= mem_elem[rd_addr0];
      elem_rd1 <= mem_elem[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      mem_scr[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      scr_rd0 <= mem_scr[rd_addr0];
      scr_rd1 <= mem_scr[rd_addr1];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      bank    <= 1'b0;
      width   <= '0;
      lo      <= '0;
      mid     <= '0;
      hi      <= '0;
      a       <= '0;
      b       <= '0;
      k       <= '0;
      e       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (store_room) begin
              count <= count_inc;
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              bank  <= 1'b0;
              width <= CNT_W'(1);
              e     <= '0;
              // a single value needs no merging
              if (store_room ? (count_inc > CNT_W'(1)) : 1'b1) begin
                state <= S_PASS;
              end else begin
                state <= S_EM_RD;
              end
            end
          end
        end
        S_PASS: begin
          lo    <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          mid   <= mid_c;
          hi    <= hi_c;
          a     <= lo;
          b     <= mid_c;
          k     <= lo;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          k <= k_inc;
          if (take_a) begin
            a <= a + CNT_W'(1);
          end else begin
            b <= b + CNT_W'(1);
          end
          if (k_inc == hi) begin
            if (sum_hi >= {1'b0, count}) begin
              // pass done: swap stores, double the run width
              bank  <= !bank;
              width <= width_dbl[CNT_W-1:0];
              if (width_dbl >= {1'b0, count}) begin
                state <= S_EM_RD;
              end else begin
                state <= S_PASS;
              end
            end else begin
              lo    <= sum_hi[CNT_W-1:0];
              state <= S_RUN;
            end
          end else begin
            state <= S_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_SHOW;
        end
        S_EM_SHOW: begin
          if (res_ready) begin
            if (final_res) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              e     <= e + IDX_W'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word: read data holds while the sequencer waits in S_EM_SHOW.
  assign res_valid    = (state == S_EM_SHOW);
  assign sorted_value = src0;
  assign final_res    = ({1'b0, e} == (count - CNT_W'(1)));
  assign overflow     = dropped;

endmodule

[src/merge_sorter_check.sv]
// Port-level checker for the merge sorter, bound to the top level.
module merge_sorter_check (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_ready,
  input ms_pkg::value_t value,
  input logic          last,
  input logic          res_valid,
  input logic          res_ready,
  input ms_pkg::value_t sorted_value,
  input logic          final_res,
  input logic          overflow
);
  import ms_pkg::*;

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sorted_value)
      && $stable(final_res) && $stable(overflow))
    else $error("result word changed while stalled");

  // Input and output sides never open together.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && res_valid))
    else $error("item_ready and res_valid both high");

  // After the last word the block stops taking input.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && last |=> !item_ready)
    else $error("input still open after last word");

  // The final result ends the burst.
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && final_res |=> !res_valid && item_ready)
    else $error("results continue after final word");

  // Overflow is one value for the whole burst.
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    res_valid && !final_res |=> $stable(overflow))
    else $error("overflow changed within a burst");

endmodule

bind merge_sorter merge_sorter_check u_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .value        (value),
  .last         (last),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .sorted_value (sorted_value),
  .final_res    (final_res),
  .overflow     (overflow)
);
